### rtl/triangle_tangent_basis_defines.svh
// Assertion macros shared by the tangent-basis RTL.
// Needs clk and rst_n in the scope of each use; empty under SYNTHESIS.
`ifndef TRIANGLE_TANGENT_BASIS_DEFINES_SVH
`define TRIANGLE_TANGENT_BASIS_DEFINES_SVH
`ifndef SYNTHESIS
`define TTB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttb assertion failed");
`define TTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttb assertion failed");
`else
`define TTB_ASSERT_IMPL(label, ante, cons)
`define TTB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/ttb_pkg.sv
// Types, widths and constants of the tangent-basis block.
// No dependencies; used by every RTL module.
`timescale 1ns / 1ps
package ttb_pkg;
  localparam int COMP_W    = 21;
  localparam int UV_W      = 17;
  localparam int UNIT_FRAC = 18;
  localparam int THR_W     = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1074;

  localparam int EDGE_W  = COMP_W + 1;
  localparam int DUV_W   = UV_W + 1;
  localparam int NIN_W   = 41;
  localparam int NOUT_W  = UNIT_FRAC + 2;
  localparam int NA_W    = 24;
  localparam int SUM_W   = 2 * NA_W + 2;
  localparam int ROOT_W  = NA_W + 1;
  localparam int DIVQ_W  = UNIT_FRAC + 1;
  localparam int NUM_W   = NA_W + UNIT_FRAC + 2;
  localparam int POS_W   = 6;
  localparam int UNIT_ONE = 1 << UNIT_FRAC;

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [3*COMP_W-1:0] corner_pos;
    logic [3*COMP_W-1:0] next_pos;
    logic [3*COMP_W-1:0] third_pos;
    logic [2*UV_W-1:0]   corner_uv;
    logic [2*UV_W-1:0]   next_uv;
    logic [2*UV_W-1:0]   third_uv;
    logic [3*COMP_W-1:0] corner_normal;
  } ttb_in_t;

  typedef struct packed {
    logic [3*COMP_W-1:0] tangent_out;
    logic [3*COMP_W-1:0] binormal_out;
    logic                degenerate_flag;
  } ttb_out_t;

  typedef struct packed {
    logic [2:0][EDGE_W-1:0] edge1;
    logic [2:0][EDGE_W-1:0] edge2;
    logic [1:0][DUV_W-1:0]  duv1;
    logic [1:0][DUV_W-1:0]  duv2;
    logic [3*COMP_W-1:0]    normal;
  } ttb_work_t;

  typedef logic [2:0][NIN_W-1:0]  ttb_nvec_t;
  typedef logic [2:0][NOUT_W-1:0] ttb_uvec_t;

  typedef struct packed {
    logic [3*COMP_W-1:0] normal;
    logic                degen;
  } ttb_side_t;

  typedef struct packed {
    logic                 valid;
    ttb_side_t            side;
    logic [2:0]           neg;
    logic                 zero;
    logic [2:0][NA_W-1:0] a;
  } ttb_nctx_t;
endpackage

### rtl/ttb_front.sv
// Front end: takes corner transactions, forms edges and UV deltas, queues them.
// Depends on ttb_pkg and triangle_tangent_basis_defines.svh.
`timescale 1ns / 1ps
`include "triangle_tangent_basis_defines.svh"
module ttb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  ttb_pkg::ttb_in_t   in_data,
  input  logic               take,
  output logic               q_valid,
  output ttb_pkg::ttb_work_t q_data
);
  localparam logic [ttb_pkg::QCNT_W-1:0] DEPTH = ttb_pkg::QCNT_W'(ttb_pkg::Q_DEPTH);

  ttb_pkg::ttb_work_t               work;
  ttb_pkg::ttb_work_t               mem_r [ttb_pkg::Q_DEPTH];
  logic [ttb_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [ttb_pkg::QCNT_W-1:0]       cnt_r;
  logic                             acc, deq;

  always_comb begin
    logic signed [ttb_pkg::COMP_W-1:0] c, n, t;
    logic [ttb_pkg::UV_W-1:0] cu, cv, nu, nv, tu, tv;
    for (int i = 0; i < 3; i++) begin
      c = $signed(in_data.corner_pos[i*ttb_pkg::COMP_W +: ttb_pkg::COMP_W]);
      n = $signed(in_data.next_pos[i*ttb_pkg::COMP_W +: ttb_pkg::COMP_W]);
      t = $signed(in_data.third_pos[i*ttb_pkg::COMP_W +: ttb_pkg::COMP_W]);
      work.edge1[i] = ttb_pkg::EDGE_W'(n) - ttb_pkg::EDGE_W'(c);
      work.edge2[i] = ttb_pkg::EDGE_W'(t) - ttb_pkg::EDGE_W'(c);
    end
    cu = in_data.corner_uv[ttb_pkg::UV_W-1:0];
    cv = in_data.corner_uv[2*ttb_pkg::UV_W-1:ttb_pkg::UV_W];
    nu = in_data.next_uv[ttb_pkg::UV_W-1:0];
    nv = in_data.next_uv[2*ttb_pkg::UV_W-1:ttb_pkg::UV_W];
    tu = in_data.third_uv[ttb_pkg::UV_W-1:0];
    tv = in_data.third_uv[2*ttb_pkg::UV_W-1:ttb_pkg::UV_W];
    work.duv1[0] = ttb_pkg::DUV_W'(nu) - ttb_pkg::DUV_W'(cu);
    work.duv1[1] = ttb_pkg::DUV_W'(nv) - ttb_pkg::DUV_W'(cv);
    work.duv2[0] = ttb_pkg::DUV_W'(tu) - ttb_pkg::DUV_W'(cu);
    work.duv2[1] = ttb_pkg::DUV_W'(tv) - ttb_pkg::DUV_W'(cv);
    work.normal  = in_data.corner_normal;
  end

  assign full    = (cnt_r == DEPTH);
  assign q_valid = (cnt_r != '0);
  assign acc     = push && !full;
  assign deq     = take && q_valid;
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_r[wr_ptr_r] <= work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (acc) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (deq) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (acc && !deq) cnt_r <= cnt_r + 1'b1;
      else if (deq && !acc) cnt_r <= cnt_r - 1'b1;
    end
  end

  `TTB_ASSERT_NEXT(a_cnt_up, acc && !deq, cnt_r == $past(cnt_r) + 1'b1)
  `TTB_ASSERT_NEXT(a_cnt_dn, deq && !acc, cnt_r == $past(cnt_r) - 1'b1)
  `TTB_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_r <= DEPTH)
endmodule

### rtl/ttb_norm.sv
// Pipelined normalizer of a three-component vector to Q2.18 unit length.
// Range shift, squares, bit-serial square root and restoring division stages.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  ttb_pkg::ttb_nvec_t in_vec,
  input  ttb_pkg::ttb_side_t in_side,
  output logic               out_valid,
  output ttb_pkg::ttb_uvec_t out_vec,
  output ttb_pkg::ttb_side_t out_side
);
  localparam int NIN_W = ttb_pkg::NIN_W;
  localparam int NA_W  = ttb_pkg::NA_W;
  localparam int SUM_W = ttb_pkg::SUM_W;
  localparam int SW2   = SUM_W + 2;
  localparam int RW    = ttb_pkg::ROOT_W;
  localparam int QW    = ttb_pkg::DIVQ_W;
  localparam int NW    = ttb_pkg::NUM_W;
  localparam int PW    = ttb_pkg::POS_W;
  localparam int OW    = ttb_pkg::NOUT_W;
  localparam int SQ_N  = RW;
  localparam int DV_N  = QW;
  localparam logic [PW-1:0] TOP = PW'(NA_W - 1);

  // range stages
  logic [2:0][NIN_W-1:0] mag_c;
  logic [NIN_W-1:0]      max_c;
  logic [2:0][NIN_W-1:0] s1_mag_r, s2_mag_r;
  logic [2:0]            s1_neg_r, s2_neg_r;
  logic [NIN_W-1:0]      s1_max_r;
  ttb_pkg::ttb_side_t    s1_side_r, s2_side_r;
  logic                  s1_valid_r, s2_valid_r;
  logic [PW-1:0]         pos_c, s2_pos_r;
  logic                  s2_zero_r;
  ttb_pkg::ttb_nctx_t    s3_ctx_c, s3_ctx_r, s4_ctx_r, s5_ctx_r;
  logic [2:0][2*NA_W-1:0] s4_sq_r;
  logic [SUM_W-1:0]      s5_sum_r;

  always_comb begin
    max_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][NIN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      if (mag_c[i] > max_c) max_c = mag_c[i];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int b = 0; b < NIN_W; b++) begin
      if (s1_max_r[b]) pos_c = PW'(b);
    end
  end

  always_comb begin
    s3_ctx_c.valid = s2_valid_r;
    s3_ctx_c.side  = s2_side_r;
    s3_ctx_c.neg   = s2_neg_r;
    s3_ctx_c.zero  = s2_zero_r;
    for (int i = 0; i < 3; i++) begin
      if (s2_pos_r > TOP) s3_ctx_c.a[i] = NA_W'(s2_mag_r[i] >> (s2_pos_r - TOP));
      else s3_ctx_c.a[i] = NA_W'(s2_mag_r[i] << (TOP - s2_pos_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r  <= mag_c;
      s1_max_r  <= max_c;
      s1_side_r <= in_side;
      for (int i = 0; i < 3; i++) s1_neg_r[i] <= in_vec[i][NIN_W-1];
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_neg_r;
      s2_side_r <= s1_side_r;
      s2_pos_r  <= pos_c;
      s2_zero_r <= (s1_max_r == '0);
      for (int i = 0; i < 3; i++) s4_sq_r[i] <= s3_ctx_r.a[i] * s3_ctx_r.a[i];
      s5_sum_r <= SUM_W'(s4_sq_r[0]) + SUM_W'(s4_sq_r[1]) + SUM_W'(s4_sq_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_ctx_r   <= '0;
      s4_ctx_r   <= '0;
      s5_ctx_r   <= '0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_ctx_r   <= s3_ctx_c;
      s4_ctx_r   <= s3_ctx_r;
      s5_ctx_r   <= s4_ctx_r;
    end
  end

  // square root, one root bit per stage
  ttb_pkg::ttb_nctx_t sq_ctx_in  [SQ_N];
  ttb_pkg::ttb_nctx_t sq_ctx_r   [SQ_N];
  logic [SUM_W-1:0]   sq_rem_in  [SQ_N];
  logic [SUM_W-1:0]   sq_rem_r   [SQ_N];
  logic [RW-1:0]      sq_root_in [SQ_N];
  logic [RW-1:0]      sq_root_r  [SQ_N];

  assign sq_ctx_in[0]  = s5_ctx_r;
  assign sq_rem_in[0]  = s5_sum_r;
  assign sq_root_in[0] = '0;

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    localparam int K = SQ_N - 1 - j;
    logic [SW2-1:0] trial;
    logic           ge;
    if (j > 0) begin : g_link
      assign sq_ctx_in[j]  = sq_ctx_r[j-1];
      assign sq_rem_in[j]  = sq_rem_r[j-1];
      assign sq_root_in[j] = sq_root_r[j-1];
    end
    assign trial = (SW2'(sq_root_in[j]) << (K + 1)) + (SW2'(1) << (2 * K));
    assign ge    = ({2'b00, sq_rem_in[j]} >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j]  <= ge ? (sq_rem_in[j] - trial[SUM_W-1:0]) : sq_rem_in[j];
        sq_root_r[j] <= ge ? (sq_root_in[j] | (RW'(1) << K)) : sq_root_in[j];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_ctx_r[j] <= '0;
      else if (en) sq_ctx_r[j] <= sq_ctx_in[j];
    end
  end

  // rounded division, one quotient bit per stage
  ttb_pkg::ttb_nctx_t    dv_ctx_in [DV_N];
  ttb_pkg::ttb_nctx_t    dv_ctx_r  [DV_N];
  logic [RW-1:0]         dv_len_in [DV_N];
  logic [RW-1:0]         dv_len_r  [DV_N];
  logic [2:0][NW-1:0]    dv_rem_in [DV_N];
  logic [2:0][NW-1:0]    dv_rem_r  [DV_N];
  logic [2:0][QW-1:0]    dv_q_in   [DV_N];
  logic [2:0][QW-1:0]    dv_q_r    [DV_N];

  assign dv_ctx_in[0] = sq_ctx_r[SQ_N-1];
  assign dv_len_in[0] = sq_root_r[SQ_N-1];
  assign dv_q_in[0]   = '0;
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign dv_rem_in[0][i] = (NW'(sq_ctx_r[SQ_N-1].a[i]) << ttb_pkg::UNIT_FRAC)
                           + NW'(sq_root_r[SQ_N-1] >> 1);
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    localparam int K = DV_N - 1 - j;
    logic [NW-1:0] dsr;
    if (j > 0) begin : g_link
      assign dv_ctx_in[j] = dv_ctx_r[j-1];
      assign dv_len_in[j] = dv_len_r[j-1];
      assign dv_rem_in[j] = dv_rem_r[j-1];
      assign dv_q_in[j]   = dv_q_r[j-1];
    end
    assign dsr = NW'(dv_len_in[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_len_r[j] <= dv_len_in[j];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_in[j][i] >= dsr) begin
            dv_rem_r[j][i] <= dv_rem_in[j][i] - dsr;
            dv_q_r[j][i]   <= dv_q_in[j][i] | (QW'(1) << K);
          end else begin
            dv_rem_r[j][i] <= dv_rem_in[j][i];
            dv_q_r[j][i]   <= dv_q_in[j][i];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_ctx_r[j] <= '0;
      else if (en) dv_ctx_r[j] <= dv_ctx_in[j];
    end
  end

  ttb_pkg::ttb_nctx_t fin;
  logic               out_valid_r;
  ttb_pkg::ttb_uvec_t out_vec_r;
  ttb_pkg::ttb_side_t out_side_r;

  assign fin = dv_ctx_r[DV_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= fin.side;
      for (int i = 0; i < 3; i++) begin
        if (fin.zero) out_vec_r[i] <= '0;
        else if (fin.neg[i]) out_vec_r[i] <= OW'(0) - OW'(dv_q_r[DV_N-1][i]);
        else out_vec_r[i] <= OW'(dv_q_r[DV_N-1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= fin.valid;
  end

  assign out_valid = out_valid_r;
  assign out_vec   = out_vec_r;
  assign out_side  = out_side_r;
endmodule

### rtl/ttb_back.sv
// Back end: normalizes edges and UV deltas, forms the determinant, tangent,
// reference bitangent and sign-corrected binormal. Depends on ttb_pkg,
// ttb_norm and triangle_tangent_basis_defines.svh.
`timescale 1ns / 1ps
`include "triangle_tangent_basis_defines.svh"
module ttb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ttb_pkg::THR_W-1:0]      thr,
  input  logic                           q_valid,
  input  ttb_pkg::ttb_work_t             q_data,
  output logic                           take,
  input  logic                           out_pop,
  output logic                           out_empty,
  output ttb_pkg::ttb_out_t              out_data
);
  localparam int NIN_W = ttb_pkg::NIN_W;
  localparam int OW    = ttb_pkg::NOUT_W;
  localparam int CW    = ttb_pkg::COMP_W;
  localparam int PRW   = 2 * OW;
  localparam int XW    = CW + OW;
  localparam logic [3*CW-1:0] DEGEN_TAN = (3*CW)'(ttb_pkg::UNIT_ONE);
  localparam logic [CW-1:0]   BIN_LIM = CW'((1 << (CW - 1)) - 1);

  logic adv;
  logic out_valid_r;
  ttb_pkg::ttb_out_t out_data_r;

  assign adv       = !out_valid_r || out_pop;
  assign take      = adv;
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  // normalize edges and UV deltas
  ttb_pkg::ttb_nvec_t vin_e1, vin_e2, vin_d1, vin_d2;
  ttb_pkg::ttb_uvec_t e1, e2, d1, d2;
  ttb_pkg::ttb_side_t a_side_in, a_side;
  logic               a_valid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vin_e1[i] = NIN_W'($signed(q_data.edge1[i]));
      vin_e2[i] = NIN_W'($signed(q_data.edge2[i]));
    end
    for (int i = 0; i < 2; i++) begin
      vin_d1[i] = NIN_W'($signed(q_data.duv1[i]));
      vin_d2[i] = NIN_W'($signed(q_data.duv2[i]));
    end
    vin_d1[2] = '0;
    vin_d2[2] = '0;
    a_side_in.normal = q_data.normal;
    a_side_in.degen  = 1'b0;
  end

  ttb_norm u_norm_e1 (.clk, .rst_n, .en(adv), .in_valid(q_valid), .in_vec(vin_e1),
    .in_side(a_side_in), .out_valid(a_valid), .out_vec(e1), .out_side(a_side));
  ttb_norm u_norm_e2 (.clk, .rst_n, .en(adv), .in_valid(q_valid), .in_vec(vin_e2),
    .in_side('0), .out_valid(), .out_vec(e2), .out_side());
  ttb_norm u_norm_d1 (.clk, .rst_n, .en(adv), .in_valid(q_valid), .in_vec(vin_d1),
    .in_side('0), .out_valid(), .out_vec(d1), .out_side());
  ttb_norm u_norm_d2 (.clk, .rst_n, .en(adv), .in_valid(q_valid), .in_vec(vin_d2),
    .in_side('0), .out_valid(), .out_vec(d2), .out_side());

  // products
  logic signed [PRW-1:0] p_t1_r [3], p_t2_r [3], p_b1_r [3], p_b2_r [3];
  logic signed [PRW-1:0] p_da_r, p_db_r;
  logic [3*CW-1:0]       p_nrm_r;
  logic                  p_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p_t1_r[i] <= $signed(e1[i]) * $signed(d2[1]);
        p_t2_r[i] <= $signed(e2[i]) * $signed(d1[1]);
        p_b1_r[i] <= $signed(e2[i]) * $signed(d1[0]);
        p_b2_r[i] <= $signed(e1[i]) * $signed(d2[0]);
      end
      p_da_r  <= $signed(d1[0]) * $signed(d2[1]);
      p_db_r  <= $signed(d1[1]) * $signed(d2[0]);
      p_nrm_r <= a_side.normal;
    end
  end

  // determinant and weighted edges
  logic signed [PRW:0]   det_raw;
  logic [PRW:0]          det_abs;
  logic [PRW+1:0]        det_sum;
  logic [PRW-6:0]        det_rnd;
  logic [PRW-6:0]        q_det_mag_r;
  logic                  q_det_neg_r;
  ttb_pkg::ttb_nvec_t    q_tr_r, q_br_r;
  logic [3*CW-1:0]       q_nrm_r;
  logic                  q_valid_r;

  always_comb begin
    det_raw = p_da_r - p_db_r;
    det_abs = det_raw[PRW] ? (~det_raw + 1'b1) : det_raw;
    det_sum = {1'b0, det_abs} + (PRW+2)'(32);
    det_rnd = det_sum[PRW:6];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_det_mag_r <= det_rnd;
      q_det_neg_r <= det_raw[PRW] && (det_rnd != '0);
      for (int i = 0; i < 3; i++) begin
        q_tr_r[i] <= NIN_W'(p_t1_r[i] - p_t2_r[i]);
        q_br_r[i] <= NIN_W'(p_b1_r[i] - p_b2_r[i]);
      end
      q_nrm_r <= p_nrm_r;
    end
  end

  // degenerate test and tangent normalizers
  logic               degen;
  ttb_pkg::ttb_nvec_t vin_t, vin_r;
  ttb_pkg::ttb_side_t b_side_in, b_side;
  ttb_pkg::ttb_uvec_t tan, rfb;
  logic               b_valid;

  always_comb begin
    degen = (q_det_mag_r < (PRW-5)'(thr));
    for (int i = 0; i < 3; i++) begin
      if (degen) begin
        vin_t[i] = (i == 0) ? NIN_W'(ttb_pkg::UNIT_ONE) : '0;
        vin_r[i] = (i == 2) ? NIN_W'(ttb_pkg::UNIT_ONE) : '0;
      end else if (q_det_neg_r) begin
        vin_t[i] = ~q_tr_r[i] + 1'b1;
        vin_r[i] = ~q_br_r[i] + 1'b1;
      end else begin
        vin_t[i] = q_tr_r[i];
        vin_r[i] = q_br_r[i];
      end
    end
    b_side_in.normal = q_nrm_r;
    b_side_in.degen  = degen;
  end

  ttb_norm u_norm_tan (.clk, .rst_n, .en(adv), .in_valid(q_valid_r), .in_vec(vin_t),
    .in_side(b_side_in), .out_valid(b_valid), .out_vec(tan), .out_side(b_side));
  ttb_norm u_norm_ref (.clk, .rst_n, .en(adv), .in_valid(q_valid_r), .in_vec(vin_r),
    .in_side('0), .out_valid(), .out_vec(rfb), .out_side());

  // cross(normal, tangent)
  logic signed [CW-1:0]  nrm [3];
  logic signed [XW-1:0]  x_c1_r [3], x_c2_r [3];
  ttb_pkg::ttb_uvec_t    x_tan_r, x_ref_r;
  logic                  x_degen_r, x_valid_r;

  always_comb begin
    for (int i = 0; i < 3; i++) nrm[i] = $signed(b_side.normal[i*CW +: CW]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        x_c1_r[i] <= nrm[(i+1)%3] * $signed(tan[(i+2)%3]);
        x_c2_r[i] <= nrm[(i+2)%3] * $signed(tan[(i+1)%3]);
      end
      x_tan_r   <= tan;
      x_ref_r   <= rfb;
      x_degen_r <= b_side.degen;
    end
  end

  // round and saturate the binormal
  logic [2:0][CW-1:0]    bin_c;
  logic [2:0][CW-1:0]    y_bin_r;
  ttb_pkg::ttb_uvec_t    y_tan_r, y_ref_r;
  logic                  y_degen_r, y_valid_r;

  always_comb begin
    logic signed [XW:0] df;
    logic [XW:0]        dm;
    logic [XW+1:0]      ds;
    logic [CW-1:0]      rm;
    for (int i = 0; i < 3; i++) begin
      df = x_c1_r[i] - x_c2_r[i];
      dm = df[XW] ? (~df + 1'b1) : df;
      ds = {1'b0, dm} + ((XW+2)'(1) << (ttb_pkg::UNIT_FRAC - 1));
      rm = (ds[XW+1:ttb_pkg::UNIT_FRAC] > (XW+2-ttb_pkg::UNIT_FRAC)'(BIN_LIM)) ?
           BIN_LIM : CW'(ds[XW+1:ttb_pkg::UNIT_FRAC]);
      bin_c[i] = df[XW] ? (~rm + 1'b1) : rm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_bin_r   <= bin_c;
      y_tan_r   <= x_tan_r;
      y_ref_r   <= x_ref_r;
      y_degen_r <= x_degen_r;
    end
  end

  // dot with the reference bitangent
  logic signed [XW-1:0]  z_dp_r [3];
  logic [2:0][CW-1:0]    z_bin_r;
  ttb_pkg::ttb_uvec_t    z_tan_r;
  logic                  z_degen_r, z_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) z_dp_r[i] <= $signed(y_bin_r[i]) * $signed(y_ref_r[i]);
      z_bin_r   <= y_bin_r;
      z_tan_r   <= y_tan_r;
      z_degen_r <= y_degen_r;
    end
  end

  // flip and pack
  ttb_pkg::ttb_out_t res_c;

  always_comb begin
    logic signed [XW+1:0] dot;
    dot = (XW+2)'(z_dp_r[0]) + (XW+2)'(z_dp_r[1]) + (XW+2)'(z_dp_r[2]);
    for (int i = 0; i < 3; i++) begin
      res_c.tangent_out[i*CW +: CW]  = CW'($signed(z_tan_r[i]));
      res_c.binormal_out[i*CW +: CW] = dot[XW+1] ? (~z_bin_r[i] + 1'b1) : z_bin_r[i];
    end
    res_c.degenerate_flag = z_degen_r;
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      q_valid_r   <= 1'b0;
      x_valid_r   <= 1'b0;
      y_valid_r   <= 1'b0;
      z_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r   <= a_valid;
      q_valid_r   <= p_valid_r;
      x_valid_r   <= b_valid;
      y_valid_r   <= x_valid_r;
      z_valid_r   <= y_valid_r;
      out_valid_r <= z_valid_r;
    end
  end

  `TTB_ASSERT_IMPL(a_degen_tan, out_valid_r && out_data_r.degenerate_flag, out_data_r.tangent_out == DEGEN_TAN)
  `TTB_ASSERT_IMPL(a_degen_binx, out_valid_r && out_data_r.degenerate_flag, out_data_r.binormal_out[CW-1:0] == '0)
  `TTB_ASSERT_IMPL(a_zero_thr, out_valid_r && (thr == '0), !out_data_r.degenerate_flag)
endmodule

### rtl/triangle_tangent_basis.sv
// Tangent-space basis of one triangle corner: front queue, back pipeline, config register.
// Throughput one transaction per cycle while the output register is empty or being popped;
// the two normalizer chains (square root and divider, one bit per stage) set the depth.
// Reset clears all valid state and sets degenerate_threshold to 1074. Depends on ttb_pkg,
// ttb_front, ttb_back.
`timescale 1ns / 1ps
module triangle_tangent_basis (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  ttb_pkg::ttb_in_t                  in_data,
  input  logic                              pop,
  output logic                              empty,
  output ttb_pkg::ttb_out_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  logic [ttb_pkg::THR_W-1:0] thr_r;
  logic                      take, q_valid;
  ttb_pkg::ttb_work_t        q_data;
  logic                      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ttb_pkg::CFG_ADDR_W-1] == ttb_pkg::REG_THRESHOLD);
  assign prdata  = reg_hit ? {1'b0, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ttb_pkg::THR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      thr_r <= pwdata[ttb_pkg::THR_W-1:0];
    end
  end

  ttb_front u_front (
    .clk, .rst_n, .push, .full, .in_data,
    .take, .q_valid, .q_data
  );

  ttb_back u_back (
    .clk, .rst_n, .thr(thr_r), .q_valid, .q_data, .take,
    .out_pop(pop), .out_empty(empty), .out_data
  );
endmodule
